### hw/rtl/nvm_pkg.sv
// Shared types, constants and codes of the nearest vector match unit.
`default_nettype none
package nvm_pkg;

  localparam int unsigned MaxTrainDef = 512;
  localparam int unsigned MaxDimsDef  = 40;

  localparam int unsigned CoefW   = 24;
  localparam int unsigned DistW   = 54;
  localparam int unsigned ConfW   = 17;
  localparam int unsigned IdxW    = 9;
  localparam int unsigned DimIdxW = 6;
  localparam int unsigned NtW     = 10;
  localparam int unsigned NdW     = 6;
  localparam int unsigned ThrW    = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned QuotW   = 48;
  localparam int unsigned RootW   = 24;

  localparam int unsigned NumTrainRst = 2;
  localparam int unsigned NumDimsRst  = 1;
  localparam int unsigned ThreshRst   = 32768;
  localparam int unsigned ConfFull    = 65536;
  localparam int unsigned LimFactor   = 65025;  // 255 * 255
  localparam int unsigned RoundBias   = 127;
  localparam int unsigned Recip255    = 16843010;  // ceil(2^32 / 255)
  localparam int unsigned RecipShift  = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NUM_TRAIN = 2'd0,
    CFG_NUM_DIMS  = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_LIMIT,
    ST_CHECK,
    ST_DIV,
    ST_SQRT,
    ST_FINISH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### hw/rtl/nvm_cell.sv
// One query coefficient cell of the rotating query chain.
`default_nettype none
module nvm_cell (
  input  wire                        clk_i,
  input  nvm_pkg::cell_ctrl_t        ctrl_i,
  input  wire [nvm_pkg::CoefW-1:0]   load_val_i,
  input  wire [nvm_pkg::CoefW-1:0]   shift_val_i,
  output logic [nvm_pkg::CoefW-1:0]  value_o
);
  import nvm_pkg::*;

  logic [CoefW-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.load) begin
      value_d = load_val_i;
    end else if (ctrl_i.shift) begin
      value_d = shift_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
endmodule
`default_nettype wire

### hw/rtl/nvm_div.sv
// Restoring divider: floor(dist * 2^16 / divisor), one quotient bit per cycle.
`default_nettype none
module nvm_div #(
  parameter int unsigned NeW = 15
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  input  wire [nvm_pkg::DistW-1:0]    dist_i,
  input  wire [NeW-1:0]               divisor_i,
  output logic                        done_o,
  output logic [nvm_pkg::QuotW-1:0]   quot_o
);
  import nvm_pkg::*;

  localparam int unsigned CntW = $clog2(QuotW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [NeW-1:0]   rem_q, rem_d;
  logic [QuotW-1:0] low_q, low_d;
  logic [QuotW-1:0] quot_q, quot_d;
  logic [NeW:0]     trial;
  logic [NeW:0]     trial_sub;
  logic             ge;

  always_comb begin
    trial     = {rem_q, low_q[QuotW-1]};
    ge        = trial >= {1'b0, divisor_i};
    trial_sub = trial - {1'b0, divisor_i};
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    low_d     = low_q;
    quot_d    = quot_q;
    if (start_i) begin
      // the bits above the quotient width stay below the divisor
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dist_i[(QuotW-16) +: NeW];
      low_d  = {dist_i[QuotW-17:0], 16'h0000};
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? trial_sub[NeW-1:0] : trial[NeW-1:0];
      low_d  = {low_q[QuotW-2:0], 1'b0};
      quot_d = {quot_q[QuotW-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(QuotW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule
`default_nettype wire

### hw/rtl/nvm_isqrt.sv
// Digit-by-digit integer square root of the quotient, one result bit per cycle.
`default_nettype none
module nvm_isqrt (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  input  wire [nvm_pkg::QuotW-1:0]    value_i,
  output logic                        done_o,
  output logic [nvm_pkg::RootW-1:0]   root_o
);
  import nvm_pkg::*;

  localparam int unsigned CntW = $clog2(RootW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [QuotW-1:0] x_q, x_d;
  logic [QuotW-1:0] r_q, r_d;
  logic [QuotW-1:0] bit_q, bit_d;
  logic [QuotW:0]   trial;
  logic             ge;

  always_comb begin
    trial  = {1'b0, r_q} + {1'b0, bit_q};
    ge     = {1'b0, x_q} >= trial;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    r_d    = r_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = value_i;
      r_d    = '0;
      bit_d  = QuotW'(1) << (QuotW - 2);
    end else if (busy_q) begin
      if (ge) begin
        x_d = x_q - trial[QuotW-1:0];
        r_d = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(RootW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[RootW-1:0];
endmodule
`default_nettype wire

### hw/rtl/nearest_vector_match_unit.sv
// Nearest vector match unit: squared-distance nearest neighbour search with confidence.
// Loads and query elements: one transaction per cycle while idle.
// A query element with tlast starts a search (one coefficient per cycle, bounded by
// the single training memory read port), then drain, limit check, divider, square
// root and rounding steps, then the output register. Over the limit the divider, root
// and rounding steps are skipped.
// Input is held off for the whole search. Reset (rst_ni low, asynchronous) clears
// control state and restores the registers.
`default_nettype none
module nearest_vector_match_unit #(
  parameter int unsigned MAX_TRAIN = nvm_pkg::MaxTrainDef,
  parameter int unsigned MAX_DIMS  = nvm_pkg::MaxDimsDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration write channel
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire [nvm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire [nvm_pkg::ThrW-1:0]    cfg_data_i,
  // input stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [39:0]  s_axis_tdata,   // entry_index[8:0], dim_index[14:9], coefficient[38:15]
  input  wire         s_axis_tuser,   // operation
  input  wire         s_axis_tlast,   // end_of_query
  // result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [87:0] m_axis_tdata    // nearest_index[8:0], least_distance_sq[62:9],
                                      // confidence[79:63], accepted[80]
);
  import nvm_pkg::*;

  localparam int unsigned MemD  = MAX_TRAIN * MAX_DIMS;
  localparam int unsigned AddrW = (MemD > 1) ? $clog2(MemD) : 1;
  localparam int unsigned RowW  = $clog2(MAX_TRAIN);
  localparam int unsigned DimW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned TrW   = $clog2(MAX_TRAIN + 1);
  localparam int unsigned EdW   = $clog2(MAX_DIMS + 1);
  localparam int unsigned NeW   = $clog2(MemD + 1);
  localparam int unsigned LimW  = NeW + 16;
  localparam int unsigned DiffW = CoefW + 1;
  localparam int unsigned SqW   = 2 * CoefW + 1;
  localparam int unsigned PenW  = 2 * (RootW + 1);

  // ---------------------------------------------------------------------------
  // Input field unpacking
  // ---------------------------------------------------------------------------
  logic [IdxW-1:0]    in_entry;
  logic [DimIdxW-1:0] in_dim;
  logic [CoefW-1:0]   in_coef;
  logic               in_accept;
  logic               in_load;
  logic               in_query;
  logic               in_trigger;

  assign in_entry   = s_axis_tdata[8:0];
  assign in_dim     = s_axis_tdata[14:9];
  assign in_coef    = s_axis_tdata[38:15];
  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign in_load    = in_accept && (op_e'(s_axis_tuser) == OP_LOAD);
  assign in_query   = in_accept && (op_e'(s_axis_tuser) == OP_QUERY);
  assign in_trigger = in_query && s_axis_tlast;

  // ---------------------------------------------------------------------------
  // Configuration registers; writes land only while idle by contract
  // ---------------------------------------------------------------------------
  logic [NtW-1:0]  num_train_q;
  logic [NdW-1:0]  num_dims_q;
  logic [ThrW-1:0] threshold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_train_q <= NtW'(NumTrainRst);
      num_dims_q  <= NdW'(NumDimsRst);
      threshold_q <= ThrW'(ThreshRst);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_NUM_TRAIN: num_train_q <= cfg_data_i[NtW-1:0];
        CFG_NUM_DIMS:  num_dims_q  <= cfg_data_i[NdW-1:0];
        CFG_THRESHOLD: threshold_q <= cfg_data_i;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Clamp the counts into the range the table can hold, with at least 2 rows and 1 dim.
  logic [TrW-1:0] n_clamp;
  logic [EdW-1:0] e_clamp;

  always_comb begin
    if (32'(num_train_q) < 32'd2) begin
      n_clamp = TrW'(2);
    end else if (32'(num_train_q) > 32'(MAX_TRAIN)) begin
      n_clamp = TrW'(MAX_TRAIN);
    end else begin
      n_clamp = TrW'(num_train_q);
    end
    if (num_dims_q == '0) begin
      e_clamp = EdW'(1);
    end else if (32'(num_dims_q) > 32'(MAX_DIMS)) begin
      e_clamp = EdW'(MAX_DIMS);
    end else begin
      e_clamp = EdW'(num_dims_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Control state machine
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic           issue;
  logic           last_issue;
  logic           pipe_busy;
  logic           over_lim;
  logic           div_start;
  logic           div_done;
  logic           sqrt_start;
  logic           sqrt_done;
  logic           out_load;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_trigger) state_d = ST_SEARCH;
      ST_SEARCH: if (last_issue) state_d = ST_DRAIN;
      ST_DRAIN:  if (!pipe_busy) state_d = ST_LIMIT;
      ST_LIMIT:  state_d = ST_CHECK;
      ST_CHECK:  state_d = over_lim ? ST_DONE : ST_DIV;
      ST_DIV:    if (div_done) state_d = ST_SQRT;
      ST_SQRT:   if (sqrt_done) state_d = ST_FINISH;
      ST_FINISH: state_d = ST_DONE;
      ST_DONE:   if (!m_axis_tvalid || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    div_start     = 1'b0;
    sqrt_start    = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_SEARCH: issue = 1'b1;
      ST_CHECK:  div_start = !over_lim;
      ST_DIV:    sqrt_start = div_done;
      ST_DONE:   out_load = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Search sequencer: walk row by row, one coefficient per cycle
  // ---------------------------------------------------------------------------
  logic [TrW-1:0]   n_eff_q;
  logic [EdW-1:0]   e_eff_q;
  logic [RowW-1:0]  row_q;
  logic [DimW-1:0]  dim_q;
  logic [AddrW-1:0] addr_q;
  logic [AddrW-1:0] base_q;
  logic             dim_wrap;

  assign dim_wrap   = (EdW'(dim_q) + EdW'(1)) == e_eff_q;
  assign last_issue = issue && dim_wrap && ((TrW'(row_q) + TrW'(1)) == n_eff_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_eff_q <= TrW'(2);
      e_eff_q <= EdW'(1);
      row_q   <= '0;
      dim_q   <= '0;
      addr_q  <= '0;
      base_q  <= '0;
    end else if (in_trigger) begin
      // latch the clamped sizes for the whole search
      n_eff_q <= n_clamp;
      e_eff_q <= e_clamp;
      row_q   <= '0;
      dim_q   <= '0;
      addr_q  <= '0;
      base_q  <= '0;
    end else if (issue) begin
      if (dim_wrap) begin
        dim_q  <= '0;
        row_q  <= row_q + 1'b1;
        base_q <= base_q + AddrW'(MAX_DIMS);
        addr_q <= base_q + AddrW'(MAX_DIMS);
      end else begin
        dim_q  <= dim_q + 1'b1;
        addr_q <= addr_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Training memory: writes registered, one read per search cycle
  // ---------------------------------------------------------------------------
  logic [CoefW-1:0] train_mem [MemD];
  logic             wr_en_q;
  logic [AddrW-1:0] wr_addr_q;
  logic [CoefW-1:0] wr_data_q;
  logic [CoefW-1:0] rd_data_q;
  logic             load_ok;

  assign load_ok = in_load && (32'(in_entry) < 32'(MAX_TRAIN))
                           && (32'(in_dim) < 32'(MAX_DIMS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_en_q <= 1'b0;
    end else begin
      wr_en_q <= load_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= AddrW'(in_entry) * AddrW'(MAX_DIMS) + AddrW'(in_dim);
    wr_data_q <= in_coef;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_q) begin
      train_mem[wr_addr_q] <= wr_data_q;
    end
    if (issue) begin
      rd_data_q <= train_mem[addr_q];
    end
  end

  // ---------------------------------------------------------------------------
  // Query chain: each cell holds one coefficient; during a search the first
  // E cells rotate so the head always shows the coefficient of the current dim
  // ---------------------------------------------------------------------------
  logic [CoefW-1:0] cell_val [MAX_DIMS];

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_cell
    cell_ctrl_t       ctrl;
    logic [CoefW-1:0] shift_val;

    assign ctrl.load  = in_query && (32'(in_dim) == 32'(k));
    assign ctrl.shift = issue && (32'(e_eff_q) > 32'(k));

    if (k == MAX_DIMS - 1) begin : g_tail
      assign shift_val = cell_val[0];
    end else begin : g_mid
      assign shift_val = (32'(e_eff_q) == 32'(k + 1)) ? cell_val[0] : cell_val[k+1];
    end

    nvm_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .load_val_i (in_coef),
      .shift_val_i(shift_val),
      .value_o    (cell_val[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Distance pipeline: read -> diff -> square -> row sum -> best compare
  // ---------------------------------------------------------------------------
  logic             s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic             s1_first_q, s2_first_q, s3_first_q;
  logic             s1_last_q, s2_last_q, s3_last_q;
  logic [RowW-1:0]  s1_row_q, s2_row_q, s3_row_q, s4_row_q;
  logic [CoefW-1:0] s1_query_q;
  logic [DiffW-1:0] s2_diff_q;
  logic [SqW-1:0]   s3_sq_q;
  logic [DistW-1:0] acc_q;
  logic [DistW-1:0] s4_tot_q;
  logic [DistW-1:0] acc_sum;
  logic [DiffW-1:0] diff_abs;
  logic [DistW-1:0] best_q;
  logic [RowW-1:0]  best_idx_q;

  assign pipe_busy = s1_v_q || s2_v_q || s3_v_q || s4_v_q;
  assign diff_abs  = s2_diff_q[DiffW-1] ? (~s2_diff_q + 1'b1) : s2_diff_q;
  assign acc_sum   = (s3_first_q ? '0 : acc_q) + DistW'(s3_sq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q && s3_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= (dim_q == '0);
    s1_last_q  <= dim_wrap;
    s1_row_q   <= row_q;
    s1_query_q <= cell_val[0];
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_row_q   <= s1_row_q;
    s2_diff_q  <= DiffW'($signed(rd_data_q)) - DiffW'($signed(s1_query_q));
    s3_first_q <= s2_first_q;
    s3_last_q  <= s2_last_q;
    s3_row_q   <= s2_row_q;
    s3_sq_q    <= SqW'(diff_abs) * SqW'(diff_abs);
    if (s3_v_q) begin
      acc_q <= acc_sum;
    end
    s4_row_q <= s3_row_q;
    s4_tot_q <= acc_sum;
    // keep the first row with the strictly smallest distance
    if (s4_v_q && ((s4_row_q == '0) || (s4_tot_q < best_q))) begin
      best_q     <= s4_tot_q;
      best_idx_q <= s4_row_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Confidence: limit check, divide by N*E, square root, round by 1/255
  // ---------------------------------------------------------------------------
  logic [NeW-1:0]   ne_q;
  logic [LimW-1:0]  lim_q;
  logic [QuotW-1:0] quot;
  logic [RootW-1:0] root;
  logic [RootW:0]   biased;
  logic [PenW-1:0]  pen_prod;
  logic [ConfW-1:0] pen;
  logic [ConfW-1:0] conf_q;

  assign over_lim = best_q >= DistW'({lim_q, 16'h0000});

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DRAIN) begin
      ne_q <= NeW'(n_eff_q) * NeW'(e_eff_q);
    end
    if (state_q == ST_LIMIT) begin
      lim_q <= LimW'(ne_q) * LimW'(LimFactor);
    end
  end

  nvm_div #(
    .NeW(NeW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .dist_i   (best_q),
    .divisor_i(ne_q),
    .done_o   (div_done),
    .quot_o   (quot)
  );

  nvm_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_start),
    .value_i(quot),
    .done_o (sqrt_done),
    .root_o (root)
  );

  // floor((r + 127) / 255) by reciprocal multiplication, exact for r below 255 * 2^16
  assign biased   = {1'b0, root} + (RootW + 1)'(RoundBias);
  assign pen_prod = PenW'(biased) * PenW'(Recip255);
  assign pen      = pen_prod[RecipShift +: ConfW];

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CHECK && over_lim) begin
      conf_q <= '0;
    end else if (state_q == ST_FINISH) begin
      conf_q <= ConfW'(ConfFull) - pen;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a result while the next transaction is taken
  // ---------------------------------------------------------------------------
  logic        out_v_q;
  logic [87:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {7'b0, (conf_q >= threshold_q), conf_q, best_q, IdxW'(best_idx_q)};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (TrW'(best_idx_q) < n_eff_q))
    else $error("nearest index beyond searched rows");

  a_conf_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[79:63] <= ConfW'(ConfFull)))
    else $error("confidence above one");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid)
    else $error("loaded result not presented");

endmodule
`default_nettype wire
